// ===== hw/rtl/pte_pkg.sv =====
// Shared types and constants for the packed 12-bit table engine.
// Holds field widths, operation and status codes, and the request/response word types.
// No dependencies.
package pte_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 4096;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);

   // Field widths
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 13;
   localparam int VALUE_W  = 12;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 13;
   localparam int COUNT_W  = 13;

   // Byte-length mark: largest value is 3*(MAX_ENTRIES-1)/2 + 2
   localparam int LEN_W = $clog2((3 * (MAX_ENTRIES - 1)) / 2 + 3);

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_GET  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  entry;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

// ===== hw/rtl/pte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module pte_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/packed_12bit_table_engine.sv =====
// Top level of the packed 12-bit table engine: get, put and find on a table of
// 12-bit entries with a byte-length high-water mark.
// Depends on pte_pkg and pte_ram.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  pte_pkg::req_type (kind, index, value)
//   rsp      out        rsp_valid/rsp_stall  pte_pkg::rsp_type (status, entry, position, count)
//
// Get and put go from acceptance to the response handshake through decode, RAM read with
// count update, load of the output register and response on the port; a bad index or an
// unused kind skips the RAM read.
// Find walks the entry RAM one address per cycle through its single read port.
// After reset a clearing pass writes zero to all 4096 entries, one per cycle, and
// no word is accepted until that pass ends.
// A stalled response waits in the output register; the next word is accepted meanwhile
// and finishes once the register frees.
module packed_12bit_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pte_pkg::rsp_type rsp_data
);

   import pte_pkg::*;

   // Divide-by-3 by reciprocal: exact for any LEN_W-bit mark
   localparam int SHIFT  = LEN_W + 1;
   localparam int RECIP  = (2 ** SHIFT) / 3 + 1;
   localparam int PROD_W = LEN_W + SHIFT;

   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(MAX_ENTRIES);
   localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(MAX_ENTRIES - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   req_type             op_ff, op_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_entry_ff, res_entry_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;
   logic [COUNT_W-1:0]  scan_ff, scan_in;
   logic [ADDR_W-1:0]   chk_ff, chk_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;

   logic                index_ok;
   logic [INDEX_W-1:0]  idx_m1;
   logic [ADDR_W-1:0]   slot;
   logic [ADDR_W+1:0]   three_n;
   logic [LEN_W-1:0]    need;
   logic [COUNT_W-1:0]  count_now;
   logic                issue;
   logic                hit;
   logic                out_free;

   // Entry store
   pte_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Slot decode and mark needed for this slot: 3*n/2 + 2
   assign index_ok = (op_ff.index != '0) && (op_ff.index <= INDEX_LAST);
   assign idx_m1   = op_ff.index - INDEX_W'(1);
   assign slot     = idx_m1[ADDR_W-1:0];
   assign three_n  = {1'b0, slot, 1'b0} + {2'b00, slot};
   assign need     = LEN_W'(three_n[ADDR_W+1:1]) + LEN_W'(2);

   // Entry count = (len/3)*2, taken from the mark through the prod_ff register
   assign prod_in   = PROD_W'(len_ff) * PROD_W'(RECIP);
   assign count_now = {prod_ff[SHIFT +: COUNT_W-1], 1'b0};

   // Scan control
   assign issue    = scan_ff < count_now;
   assign hit      = chk_vld_ff && (ram_rd_data == op_ff.value);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_pos_in    = res_pos_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = slot;
      ram_wr_data   = op_ff.value;
      ram_rd_addr   = slot;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = ST_OK;
            res_entry_in  = '0;
            res_pos_in    = '0;
            scan_in       = '0;
            chk_vld_in    = 1'b0;
            state_in      = ST_DONE;
            case (op_ff.kind) inside
               KIND_GET, KIND_PUT: begin
                  if (!index_ok) begin
                     res_status_in = ST_BAD_INDEX;
                  end else begin
                     if (need > len_ff) begin
                        len_in = need;
                     end
                     ram_we   = (op_ff.kind == KIND_PUT);
                     state_in = ST_READ;
                  end
               end
               KIND_FIND: begin
                  state_in = ST_SCAN;
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            // read data for the slot arrives; the count settles once prod_ff registers the new mark, in ST_DONE
            if (op_ff.kind == KIND_GET) begin
               res_entry_in = ram_rd_data;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // one read issued and one compare per cycle
            ram_rd_addr = scan_ff[ADDR_W-1:0];
            if (hit) begin
               res_status_in = ST_OK;
               res_pos_in    = POS_W'(chk_ff) + POS_W'(1);
               state_in      = ST_DONE;
            end else if (!chk_vld_ff && !issue) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = ST_DONE;
            end else begin
               chk_in     = scan_ff[ADDR_W-1:0];
               chk_vld_in = issue;
               if (issue) begin
                  scan_in = scan_ff + COUNT_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = res_status_ff;
               rsp_data_in.entry    = res_entry_ff;
               rsp_data_in.position = res_pos_ff;
               rsp_data_in.count    = count_now;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= '0;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_pos_ff    <= res_pos_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The byte-length mark never shrinks
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (len_ff >= $past(len_ff)))
      else $error("byte-length mark decreased");

   // A miss carries no entry and no position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NOT_FOUND) |->
         (rsp_data.position == '0 && rsp_data.entry == '0))
      else $error("not-found response with nonzero entry or position");

   // A found position lies inside the reported count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.position != '0) |-> (rsp_data.position <= rsp_data.count))
      else $error("found position beyond entry count");

   // The scan never writes the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("RAM write during scan");

endmodule
